// File: rtl/core/lcdns_pkg.sv
package lcdns_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_INIT   = 2'd2;
    localparam logic [1:0] KIND_CURSOR = 2'd3;

    // Waits in microseconds.
    localparam logic [12:0] POST_SETTLE_US = 13'd50;
    localparam logic [12:0] POST_LONG_US   = 13'd2050;
    localparam logic [12:0] POST_WAKE1_US  = 13'd5050;
    localparam logic [12:0] POST_WAKE_US   = 13'd200;
    localparam logic [14:0] PRE_POWER_US   = 15'd20000;
    localparam logic [14:0] PRE_NONE_US    = 15'd0;

    // Controller commands that matter here.
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
    localparam logic [3:0] NIB_WAKE       = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;

    // Sequencer step bounds.
    localparam logic [3:0] BYTE_LAST_STEP = 4'd1;
    localparam logic [3:0] WAKE_STEPS     = 4'd4;
    localparam logic [3:0] INIT_LAST_STEP = 4'd13;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       row;
        logic [7:0] col;
    } t_req;

    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic [14:0] pre_wait_us;
        logic [12:0] post_wait_us;
        logic        last;
    } t_xfer;

    // A classified request: either the init run or one byte with its RS level.
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] data;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // One half of a byte; the low half of a clear or home command waits longer.
    function automatic t_xfer byte_xfer(logic rs, logic [7:0] data, logic low_half);
        t_xfer x;
        x.reg_select  = rs;
        x.nibble      = low_half ? data[3:0] : data[7:4];
        x.pre_wait_us = PRE_NONE_US;
        if (low_half && !rs && (data == CMD_CLEAR || data == CMD_HOME)) begin
            x.post_wait_us = POST_LONG_US;
        end else begin
            x.post_wait_us = POST_SETTLE_US;
        end
        x.last = 1'b0;
        return x;
    endfunction

    // Transfer at a given step of the power-up run.
    function automatic t_xfer init_xfer(logic [3:0] step);
        t_xfer      x;
        logic [3:0] off;
        logic [7:0] cmd;
        off = step - WAKE_STEPS;
        unique case (off[3:1])
            3'd0:    cmd = CMD_FUNC_SET;
            3'd1:    cmd = CMD_DISP_OFF;
            3'd2:    cmd = CMD_CLEAR;
            3'd3:    cmd = CMD_ENTRY_MODE;
            default: cmd = CMD_DISP_ON;
        endcase
        if (step < WAKE_STEPS) begin
            x.reg_select   = 1'b0;
            x.nibble       = (step == 4'd3) ? NIB_FOUR_BIT : NIB_WAKE;
            x.pre_wait_us  = (step == 4'd0) ? PRE_POWER_US : PRE_NONE_US;
            x.post_wait_us = (step == 4'd0) ? POST_WAKE1_US : POST_WAKE_US;
            x.last         = 1'b0;
        end else begin
            x = byte_xfer(1'b0, cmd, off[0]);
        end
        return x;
    endfunction

endpackage

// File: rtl/core/lcdns_front.sv
module lcdns_front (
    input  lcdns_pkg::t_req    i_req,
    input  logic               i_valid,
    input  lcdns_pkg::t_q_stat i_q_stat,
    output logic               o_stall,
    output logic               o_push,
    output lcdns_pkg::t_job    o_job
);
    import lcdns_pkg::*;

    // Every request reduces to the init run or a single byte with an RS level.
    always_comb begin
        o_job.is_init = (i_req.kind == KIND_INIT);
        o_job.rs      = (i_req.kind == KIND_DATA);
        unique case (i_req.kind)
            KIND_CURSOR: o_job.data = {1'b1, i_req.row, 2'b00, i_req.col[3:0]};
            default:     o_job.data = i_req.value;
        endcase
    end

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

endmodule

// File: rtl/core/lcdns_queue.sv
module lcdns_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lcdns_pkg::t_job    i_job,
    input  logic               i_pop,
    output lcdns_pkg::t_job    o_head,
    output lcdns_pkg::t_q_stat o_stat
);
    import lcdns_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_count, n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + {{QUEUE_AW{1'b0}}, i_push} - {{QUEUE_AW{1'b0}}, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

endmodule

// File: rtl/core/lcdns_back.sv
module lcdns_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcdns_pkg::t_job    i_head,
    input  lcdns_pkg::t_q_stat i_q_stat,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output lcdns_pkg::t_xfer   o_xfer
);
    import lcdns_pkg::*;

    logic [3:0] r_step, n_step;
    logic       r_valid, n_valid;
    t_xfer      r_xfer;
    t_xfer      w_xfer;
    logic       w_advance;
    logic       w_fire;

    always_comb begin
        w_advance = !r_valid || !i_stall;
        w_fire    = w_advance && !i_q_stat.empty;
        if (i_head.is_init) begin
            w_xfer      = init_xfer(r_step);
            w_xfer.last = (r_step == INIT_LAST_STEP);
        end else begin
            w_xfer      = byte_xfer(i_head.rs, i_head.data, r_step[0]);
            w_xfer.last = (r_step == BYTE_LAST_STEP);
        end
        o_pop   = w_fire && w_xfer.last;
        n_step  = w_fire ? (w_xfer.last ? 4'd0 : r_step + 4'd1) : r_step;
        n_valid = w_fire ? 1'b1 : (w_advance ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_xfer <= w_xfer;
        end
    end

    assign o_valid = r_valid;
    assign o_xfer  = r_xfer;

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= INIT_LAST_STEP)
        else $error("sequencer step out of range");

    a_step_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != 4'd0 |-> !i_q_stat.empty)
        else $error("sequencer mid-request with empty queue");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_xfer))
        else $error("stalled output item changed");

endmodule

// File: rtl/core/char_lcd_nibble_sequencer.sv
// Character LCD nibble sequencer for a controller wired in 4-bit mode. Each
// accepted request item (command byte, data byte, set cursor or initialize)
// is expanded into the run of enable pulses the controller needs; each output
// item describes one pulse: the RS level, the nibble for D7..D4, the wait
// before raising enable and the wait after it falls, plus a flag on the final
// pulse of the request. Bytes go out high nibble first. The block produces
// one output item per clock cycle when the output side is not stalled and
// a request is queued; a command, data or cursor request is two output
// items and an initialize request is fourteen, all issued from the single
// output register of the sequencer. When the block is idle, an accepted
// request is first written into the queue, and o_valid for its first output
// item then rises from the output register. A four-entry queue sits between
// the request decoder and the sequencer, so requests keep being accepted
// while earlier ones are still being sent; o_stall rises only when it is full.
module char_lcd_nibble_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  lcdns_pkg::t_req   i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output lcdns_pkg::t_xfer  o_xfer
);
    import lcdns_pkg::*;

    t_job    w_job;
    t_job    w_head;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;

    // Front end: classify the request and push it when there is room.
    lcdns_front u_front (
        .i_req    (i_req),
        .i_valid  (i_valid),
        .i_q_stat (w_q_stat),
        .o_stall  (o_stall),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    // Queue of pending requests between the two halves.
    lcdns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // Back end: walk through the pulses of the request at the queue head.
    lcdns_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_xfer   (o_xfer)
    );

endmodule

// File: test/char_lcd_nibble_sequencer_tb.sv
module char_lcd_nibble_sequencer_tb;

    import lcdns_pkg::*;

    // Timing figures that the LCD controller needs, in microseconds.
    localparam logic [12:0] SETTLE_US     = 13'd50;
    localparam logic [12:0] LONG_CMD_US   = 13'd2050;
    localparam logic [12:0] WAKE_FIRST_US = 13'd5050;
    localparam logic [12:0] WAKE_US       = 13'd200;
    localparam logic [14:0] POWER_UP_US   = 15'd20000;
    localparam logic [14:0] NO_PRE_US     = 15'd0;

    // Controller command bytes and nibbles used by the sequences.
    localparam logic [7:0] CLEAR_DISPLAY  = 8'h01;
    localparam logic [7:0] RETURN_HOME    = 8'h02;
    localparam logic [7:0] LCD_FUNC_4BIT  = 8'h28;
    localparam logic [7:0] LCD_DISP_OFF   = 8'h08;
    localparam logic [7:0] LCD_ENTRY_INC  = 8'h06;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
    localparam logic [7:0] LCD_SET_ADDR   = 8'h80;
    localparam logic [7:0] LINE2_BASE     = 8'h40;
    localparam logic [7:0] LINE1_BASE     = 8'h00;
    localparam logic [3:0] NIB_WAKE       = 4'h3;
    localparam logic [3:0] NIB_4BIT       = 4'h2;

    localparam int RANDOM_REQS  = 81;
    localparam int MAX_WAIT     = 14;
    localparam int DRAIN_CYCLES = 32;
    localparam int LIMIT_CYCLES = 200000;

    // One stimulus row. When typed is set, the two pulses of a byte request
    // are written out by hand instead of being worked out by the predictor.
    typedef struct {
        t_req        req;
        bit          typed;
        logic        rs;
        logic [3:0]  hi;
        logic [3:0]  lo;
        logic [12:0] lo_post;
    } t_case_row;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    t_req   i_req;
    logic   o_valid;
    logic   i_stall;
    t_xfer  o_xfer;

    // Enable pulses still owed by the block, oldest first.
    t_xfer      pending_pulses[$];
    t_case_row  directed_rows[$];

    int failures     = 0;
    int reqs_sent    = 0;
    int inits_sent   = 0;
    int cursors_sent = 0;
    int pulses_seen  = 0;
    int tx_quiet     = 0;
    int rx_quiet     = 0;

    char_lcd_nibble_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_xfer  (o_xfer)
    );

    // 12-unit clock, low half first.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Draws the idle time before the next item on one side. Now and then a
    // stretch of items goes by with no idling at all, so that back-to-back
    // traffic is exercised as well as gaps of every length.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            quiet_left = $urandom_range(5, 15);
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic t_xfer make_pulse(logic rs, logic [3:0] nib, logic [14:0] pre,
                                         logic [12:0] post, logic fin);
        t_xfer p;
        p.reg_select   = rs;
        p.nibble       = nib;
        p.pre_wait_us  = pre;
        p.post_wait_us = post;
        p.last         = fin;
        return p;
    endfunction

    // A byte is two pulses, high nibble first. Only a command byte that
    // clears the display or returns home needs the long wait after its
    // low nibble; the same values sent as data do not.
    task automatic queue_byte(input logic rs, input logic [7:0] b, input logic fin);
        logic [12:0] low_post;
        low_post = (!rs && (b == CLEAR_DISPLAY || b == RETURN_HOME)) ? LONG_CMD_US : SETTLE_US;
        pending_pulses.push_back(make_pulse(rs, b[7:4], NO_PRE_US, SETTLE_US, 1'b0));
        pending_pulses.push_back(make_pulse(rs, b[3:0], NO_PRE_US, low_post, fin));
    endtask

    // Predictor: appends every pulse that one accepted request item causes.
    task automatic expand_request(input t_req r);
        logic [7:0] addr;
        case (r.kind)
            KIND_CMD: begin
                queue_byte(1'b0, r.value, 1'b1);
            end
            KIND_DATA: begin
                queue_byte(1'b1, r.value, 1'b1);
            end
            KIND_CURSOR: begin
                // Any nonzero row selects the second line; the column is cut to four
                // bits, and the set-address bit keeps the byte from looking like clear or home.
                addr = (r.row ? LINE2_BASE : LINE1_BASE) + {4'h0, r.col[3:0]};
                queue_byte(1'b0, LCD_SET_ADDR | addr, 1'b1);
            end
            KIND_INIT: begin
                // Wake-up: three 0x3 nibbles, the first after the power-up
                // wait, then 0x2 to switch into 4-bit mode.
                pending_pulses.push_back(make_pulse(1'b0, NIB_WAKE, POWER_UP_US,
                                                    WAKE_FIRST_US, 1'b0));
                pending_pulses.push_back(make_pulse(1'b0, NIB_WAKE, NO_PRE_US, WAKE_US, 1'b0));
                pending_pulses.push_back(make_pulse(1'b0, NIB_WAKE, NO_PRE_US, WAKE_US, 1'b0));
                pending_pulses.push_back(make_pulse(1'b0, NIB_4BIT, NO_PRE_US, WAKE_US, 1'b0));
                // Configuration commands, sent as ordinary command bytes.
                queue_byte(1'b0, LCD_FUNC_4BIT, 1'b0);
                queue_byte(1'b0, LCD_DISP_OFF, 1'b0);
                queue_byte(1'b0, CLEAR_DISPLAY, 1'b0);
                queue_byte(1'b0, LCD_ENTRY_INC, 1'b0);
                queue_byte(1'b0, LCD_DISP_ON, 1'b1);
            end
        endcase
    endtask

    // Compares one accepted output item with the oldest pulse still owed.
    task automatic check_pulse(input t_xfer got);
        t_xfer want;
        if (pending_pulses.size() == 0) begin
            $error("unexpected item: rs %b nibble %h pre %0d post %0d last %b",
                   got.reg_select, got.nibble, got.pre_wait_us, got.post_wait_us, got.last);
            failures++;
        end else begin
            want = pending_pulses.pop_front();
            if (got.reg_select !== want.reg_select) begin
                $error("reg_select: expected %b, got %b", want.reg_select, got.reg_select);
                failures++;
            end
            if (got.nibble !== want.nibble) begin
                $error("nibble: expected %h, got %h", want.nibble, got.nibble);
                failures++;
            end
            if (got.pre_wait_us !== want.pre_wait_us) begin
                $error("pre_wait_us: expected %0d, got %0d", want.pre_wait_us, got.pre_wait_us);
                failures++;
            end
            if (got.post_wait_us !== want.post_wait_us) begin
                $error("post_wait_us: expected %0d, got %0d",
                       want.post_wait_us, got.post_wait_us);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, got.last);
                failures++;
            end
        end
    endtask

    task automatic add_row(input logic [1:0] kind, input logic [7:0] value, input logic row,
                           input logic [7:0] col, input bit typed, input logic rs,
                           input logic [3:0] hi, input logic [3:0] lo,
                           input logic [12:0] lo_post);
        t_case_row c;
        c.req.kind  = kind;
        c.req.value = value;
        c.req.row   = row;
        c.req.col   = col;
        c.typed     = typed;
        c.rs        = rs;
        c.hi        = hi;
        c.lo        = lo;
        c.lo_post   = lo_post;
        directed_rows.push_back(c);
    endtask

    // Random request: mostly bytes and cursor moves with random content,
    // clear and home mixed in, and an occasional initialize run. Fields a
    // kind does not use are still random so that ignoring them is checked.
    function automatic t_case_row random_row();
        t_case_row c;
        int        pick;
        c.typed     = 1'b0;
        c.rs        = 1'b0;
        c.hi        = 4'h0;
        c.lo        = 4'h0;
        c.lo_post   = SETTLE_US;
        c.req.value = 8'($urandom);
        c.req.row   = 1'($urandom);
        c.req.col   = 8'($urandom);
        pick        = $urandom_range(0, 99);
        if (pick < 30) begin
            c.req.kind = KIND_CMD;
        end else if (pick < 38) begin
            c.req.kind  = KIND_CMD;
            c.req.value = $urandom_range(0, 1) ? CLEAR_DISPLAY : RETURN_HOME;
        end else if (pick < 68) begin
            c.req.kind = KIND_DATA;
        end else if (pick < 90) begin
            c.req.kind = KIND_CURSOR;
        end else begin
            c.req.kind = KIND_INIT;
        end
        return c;
    endfunction

    // Offers one request item after the given idle time and holds it,
    // unchanged, until the block takes it. Entered and left at a falling
    // edge; on return valid is still high so the next item can follow
    // back to back.
    task automatic offer_request(input t_case_row c, input int gap);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_req   = c.req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (c.typed) begin
            pending_pulses.push_back(make_pulse(c.rs, c.hi, NO_PRE_US, SETTLE_US, 1'b0));
            pending_pulses.push_back(make_pulse(c.rs, c.lo, NO_PRE_US, c.lo_post, 1'b1));
        end else begin
            expand_request(c.req);
        end
        reqs_sent++;
        if (c.req.kind == KIND_INIT) inits_sent++;
        if (c.req.kind == KIND_CURSOR) cursors_sent++;
        @(negedge i_clk);
    endtask

    // Output side: stalls a random number of cycles before taking each
    // item, and checks every item that it takes.
    initial begin : pulse_sink
        int hold_left;
        hold_left = 0;
        i_stall   = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            i_stall = (hold_left > 0);
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                check_pulse(o_xfer);
                pulses_seen++;
                hold_left = draw_wait(rx_quiet);
            end else if (i_stall) begin
                hold_left--;
            end
        end
    end

    // Request side: reset, the directed table, then the random items.
    initial begin : request_source
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;

        // Extremes of every field, both RS levels, clear and home as
        // commands and as data, cursor on both lines with the unused column
        // bits set, and initialize with its ignored fields at both extremes.
        add_row(KIND_CMD,    8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 4'h0, 4'h0, SETTLE_US);
        add_row(KIND_CMD,    8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0, 4'hF, 4'hF, SETTLE_US);
        add_row(KIND_CMD,    8'h01, 1'b0, 8'h00, 1'b1, 1'b0, 4'h0, 4'h1, LONG_CMD_US);
        add_row(KIND_CMD,    8'h02, 1'b1, 8'hFF, 1'b1, 1'b0, 4'h0, 4'h2, LONG_CMD_US);
        add_row(KIND_DATA,   8'h01, 1'b0, 8'h00, 1'b1, 1'b1, 4'h0, 4'h1, SETTLE_US);
        add_row(KIND_DATA,   8'h02, 1'b1, 8'hFF, 1'b1, 1'b1, 4'h0, 4'h2, SETTLE_US);
        add_row(KIND_DATA,   8'h00, 1'b1, 8'hFF, 1'b1, 1'b1, 4'h0, 4'h0, SETTLE_US);
        add_row(KIND_DATA,   8'hFF, 1'b0, 8'h00, 1'b1, 1'b1, 4'hF, 4'hF, SETTLE_US);
        add_row(KIND_CURSOR, 8'hFF, 1'b0, 8'h00, 1'b1, 1'b0, 4'h8, 4'h0, SETTLE_US);
        add_row(KIND_CURSOR, 8'h00, 1'b1, 8'h0F, 1'b1, 1'b0, 4'hC, 4'hF, SETTLE_US);
        add_row(KIND_CURSOR, 8'h01, 1'b1, 8'hFF, 1'b1, 1'b0, 4'hC, 4'hF, SETTLE_US);
        add_row(KIND_CURSOR, 8'h02, 1'b0, 8'hF0, 1'b1, 1'b0, 4'h8, 4'h0, SETTLE_US);
        add_row(KIND_INIT,   8'hFF, 1'b1, 8'hFF, 1'b0, 1'b0, 4'h0, 4'h0, SETTLE_US);
        add_row(KIND_INIT,   8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0, SETTLE_US);
        add_row(KIND_CMD,    8'h03, 1'b0, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0, SETTLE_US);
        add_row(KIND_CMD,    8'h80, 1'b1, 8'hAA, 1'b0, 1'b0, 4'h0, 4'h0, SETTLE_US);
        add_row(KIND_DATA,   8'hA5, 1'b1, 8'h5A, 1'b0, 1'b0, 4'h0, 4'h0, SETTLE_US);
        add_row(KIND_CURSOR, 8'h5A, 1'b1, 8'h37, 1'b0, 1'b0, 4'h0, 4'h0, SETTLE_US);
        add_row(KIND_CMD,    8'h10, 1'b0, 8'h55, 1'b0, 1'b0, 4'h0, 4'h0, SETTLE_US);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) begin
            offer_request(directed_rows[k], draw_wait(tx_quiet));
        end

        for (int n = 0; n < RANDOM_REQS; n++) begin
            // Halfway through, let the block run completely dry before
            // offering more, so a request also meets an idle pipeline.
            if (n == RANDOM_REQS / 2) begin
                i_valid = 1'b0;
                while (pending_pulses.size() != 0) @(negedge i_clk);
            end
            offer_request(random_row(), draw_wait(tx_quiet));
        end
        i_valid = 1'b0;

        // Wait for every owed pulse, then a little longer so that any
        // surplus output item would still be caught.
        while (pending_pulses.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d requests (%0d initialize, %0d cursor) and checked %0d pulses.",
                 reqs_sent, inits_sent, cursors_sent, pulses_seen);
        $display("Both sides idled and stalled at random; %0d mismatches found.", failures);
        if (failures == 0) begin
            $display("char_lcd_nibble_sequencer_tb: PASS");
        end else begin
            $display("char_lcd_nibble_sequencer_tb: FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #(12 * LIMIT_CYCLES);
        $display("char_lcd_nibble_sequencer_tb: FAIL");
        $finish;
    end

endmodule
